>>> hdl/gray_laplacian_median_3x3_top_assert.svh
// assertion macros for the filter's port checker
`ifndef GRAY_LAPLACIAN_MEDIAN_3X3_TOP_ASSERT_SVH
`define GRAY_LAPLACIAN_MEDIAN_3X3_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define GLM3_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define GLM3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/glm3_pkg.sv
// shared constants, types and register codes of the gray laplacian and median filter
package glm3_pkg;

    // default line store depth
    localparam int MAX_WIDTH_DEF = 2048;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // field widths
    localparam int PIX_W      = 8;
    localparam int ROW_W      = 16;
    localparam int OUT_COL_W  = 11;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_PAD_W  = OUT_DATA_W - (ROW_W + OUT_COL_W + 2 * PIX_W);
    localparam int PROD_W     = 24;

    // register reset values
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

    // q0.16 luma weights, summing to 65536
    localparam logic [15:0] W_RED   = 16'd19595;
    localparam logic [15:0] W_GREEN = 16'd38470;
    localparam logic [15:0] W_BLUE  = 16'd7471;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    // per-item classification from the front
    typedef struct packed {
        logic emit;
        logic last;
    } item_flags_t;

endpackage

>>> hdl/glm3_ram.sv
// generic simple dual-port ram with registered read
module glm3_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/glm3_fifo.sv
// short first-in first-out queue between front and back
module glm3_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

endmodule

>>> hdl/glm3_front.sv
// front end: config registers, raster counters, gray conversion and classification
module glm3_front #(
    parameter int MAX_WIDTH = 2048,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [glm3_pkg::IN_DATA_W-1:0]         s_axis_tdata,
    input  logic                                   cfg_we,
    input  logic [glm3_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [glm3_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                   push,
    input  logic                                   q_full,
    output logic [glm3_pkg::PIX_W-1:0]             item_gray,
    output logic [COL_W-1:0]                       item_col,
    output logic [glm3_pkg::ROW_W-1:0]             item_row,
    output glm3_pkg::item_flags_t                  item_flags
);

    import glm3_pkg::*;

    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam int WID_W = (CNT_W > WIDTH_W) ? CNT_W : WIDTH_W;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic                f_valid_reg;
    logic [PROD_W-1:0]   prod_r_reg, prod_g_reg, prod_b_reg;
    logic [COL_W-1:0]    col_item_reg;
    logic [ROW_W-1:0]    row_item_reg;
    item_flags_t         flags_item_reg;
    item_flags_t         flags_next;

    logic [WID_W-1:0]    width_ext, width_eff, width_m1;
    logic [COL_W-1:0]    col_last;
    logic [HEIGHT_W-1:0] height_eff;
    logic [ROW_W-1:0]    row_last;
    logic                accept;
    logic [PROD_W-1:0]   gray_sum;
    logic [PIX_W-1:0]    red, green, blue;

    assign red   = s_axis_tdata[PIX_W-1:0];
    assign green = s_axis_tdata[2*PIX_W-1:PIX_W];
    assign blue  = s_axis_tdata[3*PIX_W-1:2*PIX_W];

    // effective frame size: width clamped between 3 and the line store depth, height at least 3
    always_comb
    begin
        width_ext = WID_W'(width_reg);
        if (width_ext < WID_W'(3))
        begin
            width_eff = WID_W'(3);
        end
        else if (width_ext > WID_W'(MAX_WIDTH))
        begin
            width_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end
        width_m1   = width_eff - WID_W'(1);
        col_last   = width_m1[COL_W-1:0];
        height_eff = (height_reg < HEIGHT_W'(3)) ? HEIGHT_W'(3) : height_reg;
        row_last   = ROW_W'(height_eff - HEIGHT_W'(1));
    end

    // handshake: one staged item, drained into the queue
    assign s_axis_tready = !f_valid_reg || !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = f_valid_reg && !q_full;

    // classification and raster advance
    always_comb
    begin
        flags_next.emit = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        flags_next.last = (row_reg == row_last) && (col_reg == col_last);
        col_next = col_reg + COL_W'(1);
        row_next = row_reg;
        if (col_reg == col_last)
        begin
            col_next = '0;
            row_next = (row_reg == row_last) ? '0 : row_reg + ROW_W'(1);
        end
    end

    // control state and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                    REG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s_axis_tready)
            begin
                f_valid_reg <= s_axis_tvalid;
            end
        end
    end

    // weighted products and item position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_r_reg     <= PROD_W'(W_RED) * PROD_W'(red);
            prod_g_reg     <= PROD_W'(W_GREEN) * PROD_W'(green);
            prod_b_reg     <= PROD_W'(W_BLUE) * PROD_W'(blue);
            col_item_reg   <= col_reg;
            row_item_reg   <= row_reg;
            flags_item_reg <= flags_next;
        end
    end

    // gray is the integer part of the weighted sum
    assign gray_sum   = prod_r_reg + prod_g_reg + prod_b_reg;
    assign item_gray  = gray_sum[PROD_W-1 -: PIX_W];
    assign item_col   = col_item_reg;
    assign item_row   = row_item_reg;
    assign item_flags = flags_item_reg;

endmodule

>>> hdl/glm3_back.sv
// back end: line stores, 3x3 window, laplacian and pipelined median network
module glm3_back #(
    parameter int MAX_WIDTH = 2048,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    output logic                               pop,
    input  logic [glm3_pkg::PIX_W-1:0]         item_gray,
    input  logic [COL_W-1:0]                   item_col,
    input  logic [glm3_pkg::ROW_W-1:0]         item_row,
    input  glm3_pkg::item_flags_t              item_flags,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_row [15:0], out_col [26:16], laplacian [34:27], median [42:35], zeros above
    output logic [glm3_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast
);

    import glm3_pkg::*;

    localparam int EXT_W = (COL_W > OUT_COL_W) ? COL_W : OUT_COL_W;

    // returns {larger, smaller}
    function automatic logic [2*PIX_W-1:0] sort_pair(input logic [PIX_W-1:0] a,
                                                     input logic [PIX_W-1:0] b);
        return (a > b) ? {a, b} : {b, a};
    endfunction

    logic                 advance;

    // stage 0: line store read in flight
    logic                 s0_valid_reg;
    logic [PIX_W-1:0]     s0_gray_reg;
    logic [COL_W-1:0]     s0_col_reg;
    logic [ROW_W-1:0]     s0_row_reg;
    item_flags_t          s0_flags_reg;
    logic [PIX_W-1:0]     prev_rd, prev2_rd;
    logic                 ls_wr_en;

    // stage 1: window
    logic                 s1_valid_reg;
    logic [PIX_W-1:0]     win_reg [9];
    logic [COL_W-1:0]     s1_col_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    item_flags_t          s1_flags_reg;

    // stage 2: laplacian and first median layers
    logic                 s2_valid_reg;
    logic [PIX_W-1:0]     lap_reg_s2;
    logic [PIX_W-1:0]     med2_reg [9];
    logic [COL_W-1:0]     s2_col_reg;
    logic [ROW_W-1:0]     s2_row_reg;
    item_flags_t          s2_flags_reg;

    // stage 3: middle median layers
    logic                 s3_valid_reg;
    logic [PIX_W-1:0]     lap_reg_s3;
    logic [PIX_W-1:0]     med3_reg [9];
    logic [COL_W-1:0]     s3_col_reg;
    logic [ROW_W-1:0]     s3_row_reg;
    item_flags_t          s3_flags_reg;

    // output register
    logic                 out_valid_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic [PIX_W-1:0]     out_lap_reg;
    logic [PIX_W-1:0]     out_med_reg;
    logic                 out_last_reg;

    logic [PIX_W+1:0]     lap_pos, lap_neg, lap_diff;
    logic [PIX_W-1:0]     lap_next;
    logic [PIX_W-1:0]     med_a [9];
    logic [PIX_W-1:0]     med_b [9];
    logic [PIX_W-1:0]     med_c [9];
    logic [PIX_W-1:0]     med_next;
    logic [EXT_W-1:0]     col_ext;
    logic [OUT_COL_W-1:0] out_col_next;
    logic [ROW_W-1:0]     out_row_next;

    // whole pipeline moves when the output register is free or being taken
    assign advance = !out_valid_reg || m_axis_tready;
    assign pop     = advance && !q_empty;
    assign ls_wr_en = advance && s0_valid_reg;

    // line store of the previous row
    glm3_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_prev (
        .clk     (clk),
        .wr_en   (ls_wr_en),
        .wr_addr (s0_col_reg),
        .wr_data (s0_gray_reg),
        .rd_en   (pop),
        .rd_addr (item_col),
        .rd_data (prev_rd)
    );

    // line store of the row before that
    glm3_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_prev2 (
        .clk     (clk),
        .wr_en   (ls_wr_en),
        .wr_addr (s0_col_reg),
        .wr_data (prev_rd),
        .rd_en   (pop),
        .rd_addr (item_col),
        .rd_data (prev2_rd)
    );

    // absolute 4-neighbour laplacian, clamped
    always_comb
    begin
        lap_pos  = {win_reg[4], 2'b00};
        lap_neg  = (PIX_W+2)'(win_reg[1]) + (PIX_W+2)'(win_reg[3])
                 + (PIX_W+2)'(win_reg[5]) + (PIX_W+2)'(win_reg[7]);
        lap_diff = (lap_pos >= lap_neg) ? lap_pos - lap_neg : lap_neg - lap_pos;
        lap_next = (lap_diff > (PIX_W+2)'(255)) ? '1 : lap_diff[PIX_W-1:0];
    end

    // median layers one to three: sort each row
    always_comb
    begin
        med_a = win_reg;
        {med_a[2], med_a[1]} = sort_pair(med_a[1], med_a[2]);
        {med_a[5], med_a[4]} = sort_pair(med_a[4], med_a[5]);
        {med_a[8], med_a[7]} = sort_pair(med_a[7], med_a[8]);
        {med_a[1], med_a[0]} = sort_pair(med_a[0], med_a[1]);
        {med_a[4], med_a[3]} = sort_pair(med_a[3], med_a[4]);
        {med_a[7], med_a[6]} = sort_pair(med_a[6], med_a[7]);
        {med_a[2], med_a[1]} = sort_pair(med_a[1], med_a[2]);
        {med_a[5], med_a[4]} = sort_pair(med_a[4], med_a[5]);
        {med_a[8], med_a[7]} = sort_pair(med_a[7], med_a[8]);
    end

    // median layers four to six: across columns
    always_comb
    begin
        med_b = med2_reg;
        {med_b[3], med_b[0]} = sort_pair(med_b[0], med_b[3]);
        {med_b[8], med_b[5]} = sort_pair(med_b[5], med_b[8]);
        {med_b[7], med_b[4]} = sort_pair(med_b[4], med_b[7]);
        {med_b[6], med_b[3]} = sort_pair(med_b[3], med_b[6]);
        {med_b[4], med_b[1]} = sort_pair(med_b[1], med_b[4]);
        {med_b[5], med_b[2]} = sort_pair(med_b[2], med_b[5]);
        {med_b[7], med_b[4]} = sort_pair(med_b[4], med_b[7]);
    end

    // median layers seven to nine: final pick of the centre
    always_comb
    begin
        med_c = med3_reg;
        {med_c[2], med_c[4]} = sort_pair(med_c[4], med_c[2]);
        {med_c[4], med_c[6]} = sort_pair(med_c[6], med_c[4]);
        {med_c[2], med_c[4]} = sort_pair(med_c[4], med_c[2]);
        med_next = med_c[4];
    end

    // reported position is one row and one column behind the arriving pixel
    always_comb
    begin
        col_ext      = EXT_W'(s3_col_reg) - EXT_W'(1);
        out_col_next = col_ext[OUT_COL_W-1:0];
        out_row_next = s3_row_reg - ROW_W'(1);
    end

    // stage valids and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            s0_valid_reg  <= pop;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg && s3_flags_reg.emit;
            if (s0_valid_reg)
            begin
                // shift one column left, new column enters at the right
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= prev2_rd;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= prev_rd;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= s0_gray_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (pop)
            begin
                s0_gray_reg  <= item_gray;
                s0_col_reg   <= item_col;
                s0_row_reg   <= item_row;
                s0_flags_reg <= item_flags;
            end
            if (s0_valid_reg)
            begin
                s1_col_reg   <= s0_col_reg;
                s1_row_reg   <= s0_row_reg;
                s1_flags_reg <= s0_flags_reg;
            end
            if (s1_valid_reg)
            begin
                lap_reg_s2   <= lap_next;
                med2_reg     <= med_a;
                s2_col_reg   <= s1_col_reg;
                s2_row_reg   <= s1_row_reg;
                s2_flags_reg <= s1_flags_reg;
            end
            if (s2_valid_reg)
            begin
                lap_reg_s3   <= lap_reg_s2;
                med3_reg     <= med_b;
                s3_col_reg   <= s2_col_reg;
                s3_row_reg   <= s2_row_reg;
                s3_flags_reg <= s2_flags_reg;
            end
            if (s3_valid_reg)
            begin
                out_row_reg  <= out_row_next;
                out_col_reg  <= out_col_next;
                out_lap_reg  <= lap_reg_s3;
                out_med_reg  <= med_next;
                out_last_reg <= s3_flags_reg.last;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_med_reg, out_lap_reg, out_col_reg, out_row_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> hdl/gray_laplacian_median_3x3_top.sv
// Streaming 3x3 Laplacian and median filter on the gray image of an RGB raster stream.
// Takes one pixel per clock and gives at most one item per pixel, for interior pixels
// only; with both sides always ready the sustained rate is one pixel per cycle, set by
// the one read and one write that each line store takes per cycle. After the edge that
// accepts a pixel registers its products, its item passes through the queue, the line
// store read, the window, two median network stages and the output register. A stall on
// the output freezes the back end; the queue lets the front keep taking pixels until
// it fills. Writing image_width or image_height restarts the frame at row 0, column 0;
// write them only while the block is idle. The line stores need no clearing pass:
// entries not yet written are read only for rows that are never reported.
module gray_laplacian_median_3x3_top #(
    parameter int MAX_WIDTH = glm3_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [glm3_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_row [15:0], out_col [26:16], laplacian [34:27], median [42:35], zeros above
    output logic [glm3_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // frame_last
    output logic                               m_axis_tlast,
    input  logic                               cfg_we,
    input  logic [glm3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [glm3_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import glm3_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ITEM_W = PIX_W + COL_W + ROW_W + $bits(item_flags_t);

    logic              q_push, q_full, q_pop, q_empty;
    logic [ITEM_W-1:0] q_wdata, q_rdata;
    logic [PIX_W-1:0]  f_gray, b_gray;
    logic [COL_W-1:0]  f_col, b_col;
    logic [ROW_W-1:0]  f_row, b_row;
    item_flags_t       f_flags, b_flags;

    // front: counters, classification, gray conversion
    glm3_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (q_push),
        .q_full        (q_full),
        .item_gray     (f_gray),
        .item_col      (f_col),
        .item_row      (f_row),
        .item_flags    (f_flags)
    );

    // queue between the two halves
    assign q_wdata = {f_flags, f_row, f_col, f_gray};

    glm3_fifo #(
        .DATA_W (ITEM_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    assign {b_flags, b_row, b_col, b_gray} = q_rdata;

    // back: line stores, window and filters
    glm3_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .pop           (q_pop),
        .item_gray     (b_gray),
        .item_col      (b_col),
        .item_row      (b_row),
        .item_flags    (b_flags),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> hdl/glm3_checker.sv
// port-level checker for the filter, bound to the top level
`include "gray_laplacian_median_3x3_top_assert.svh"

module glm3_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [glm3_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic                               m_axis_tlast
);

    import glm3_pkg::*;

    // a stalled item stays offered
    `GLM3_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "item dropped while stalled")

    // a stalled item keeps its payload
    `GLM3_ASSERT_NEXT(a_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast), "payload changed while stalled")

    // only interior rows are reported
    `GLM3_ASSERT_NOW(a_interior_row, m_axis_tvalid, m_axis_tdata[ROW_W-1:0] != '0, "border row reported")

    // nothing is offered straight after reset
    `GLM3_ASSERT_NOW(a_empty_after_reset, $rose(rst_n), !m_axis_tvalid, "item offered right after reset")

endmodule

bind gray_laplacian_median_3x3_top glm3_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
